// ===== hw/rtl/mssc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mssc_pkg;

    // data memory depth, a power of two so that the index wraps by masking
    localparam int DATA_DEPTH = 16384;
    localparam int DMEM_AW    = $clog2(DATA_DEPTH);

    localparam int RF_DEPTH = 32;

    localparam logic [5:0] OP_RTYPE = 6'd0;
    localparam logic [5:0] OP_J     = 6'd2;
    localparam logic [5:0] OP_JAL   = 6'd3;
    localparam logic [5:0] OP_BEQ   = 6'd4;
    localparam logic [5:0] OP_BNE   = 6'd5;
    localparam logic [5:0] OP_ADDI  = 6'd8;
    localparam logic [5:0] OP_SLTI  = 6'd10;
    localparam logic [5:0] OP_ANDI  = 6'd12;
    localparam logic [5:0] OP_ORI   = 6'd13;
    localparam logic [5:0] OP_LUI   = 6'd15;
    localparam logic [5:0] OP_LW    = 6'd35;
    localparam logic [5:0] OP_SW    = 6'd43;

    localparam logic [5:0] FN_SLL = 6'd0;
    localparam logic [5:0] FN_SRL = 6'd2;
    localparam logic [5:0] FN_JR  = 6'd8;
    localparam logic [5:0] FN_ADD = 6'd32;
    localparam logic [5:0] FN_SUB = 6'd34;
    localparam logic [5:0] FN_AND = 6'd36;
    localparam logic [5:0] FN_OR  = 6'd37;
    localparam logic [5:0] FN_SLT = 6'd42;

    localparam logic       ACT_EXECUTE = 1'b0;
    localparam logic       ACT_PRELOAD = 1'b1;

    localparam logic [4:0] REG_ZERO = 5'd0;
    localparam logic [4:0] REG_RA   = 5'd31;

    typedef struct packed {
        logic        action;
        logic [31:0] instruction;
        logic [13:0] preload_address;
        logic [31:0] preload_value;
    } req_t;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        reg_written;
        logic [4:0]  reg_index;
        logic [31:0] reg_value;
        logic        mem_written;
        logic        halt;
        logic        counted;
    } rsp_t;

    typedef struct packed {
        logic [31:0] npc;
        logic        rw;
        logic [4:0]  ridx;
        logic [31:0] rval;
        logic        load;
        logic        store;
        logic [31:0] maddr;
        logic        counted;
    } exec_t;

    typedef struct packed {
        logic        en;
        logic [4:0]  idx;
        logic [31:0] val;
    } rf_wr_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mssc_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface mssc_req_if;
    logic          valid;
    logic          ready;
    mssc_pkg::req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mssc_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface mssc_rsp_if;
    logic          valid;
    logic          ready;
    mssc_pkg::rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mips_subset_single_cycle_core_top.sv =====
// an accepted item executes in stage 1, then its result is offered from stage 2
// throughput: one item per cycle unless a result is held back, with no stall between
// dependent items; stage 2 exists because the register file and data memory read
// ports are registered; load data and pending writes are forwarded to the next item
// reset clears pc, pipeline valids and register file valid bits at once;
// the data memory is not cleared and holds garbage until written
`timescale 1ns / 1ps
`default_nettype none

module mips_subset_single_cycle_core_top (
    input  logic            clk,
    input  logic            rst_n,
    mssc_req_if.sink        req,
    mssc_rsp_if.source      rsp
);

    logic             req_fire;
    logic             rsp_fire;
    logic             s1_adv;

    logic             s1_valid_reg;
    mssc_pkg::req_t   s1_item_reg;
    logic [31:0]      pc_reg;
    logic [31:0]      pc_next;

    logic             s2_valid_reg;
    logic             s2_fresh_reg;
    logic [31:0]      s2_npc_reg;
    logic             s2_rw_reg;
    logic [4:0]       s2_ridx_reg;
    logic [31:0]      s2_rval_reg;
    logic             s2_load_reg;
    logic             s2_mw_reg;
    logic             s2_counted_reg;
    logic             s2_r0_prev_reg;

    logic [31:0]      s2_npc_next;
    logic             s2_rw_next;
    logic [4:0]       s2_ridx_next;
    logic [31:0]      s2_rval_next;
    logic             s2_load_next;
    logic             s2_mw_next;
    logic             s2_counted_next;

    logic [31:0]      op_a;
    logic [31:0]      op_b;
    logic             r0_nz;
    mssc_pkg::exec_t  ex;
    mssc_pkg::rf_wr_t rf_wr;
    logic             preload;

    logic                        dmem_we;
    logic                        dmem_re;
    logic [mssc_pkg::DMEM_AW-1:0] dmem_waddr;
    logic [mssc_pkg::DMEM_AW-1:0] dmem_raddr;
    logic [31:0]                 dmem_wdata;
    logic [31:0]                 dmem_q;
    logic [31:0]                 pre_addr_ext;
    logic [31:0]                 s2_value;

    assign rsp_fire  = rsp.valid && rsp.ready;
    assign s1_adv    = s1_valid_reg && (!s2_valid_reg || rsp_fire);
    assign req.ready = !s1_valid_reg || s1_adv;
    assign req_fire  = req.valid && req.ready;
    assign preload   = (s1_item_reg.action == mssc_pkg::ACT_PRELOAD);

    mssc_regfile u_regfile (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_en  (req_fire),
        .rs_idx (req.payload.instruction[25:21]),
        .rt_idx (req.payload.instruction[20:16]),
        .wr     (rf_wr),
        .a      (op_a),
        .b      (op_b),
        .r0_nz  (r0_nz)
    );

    mssc_alu u_alu (
        .instruction (s1_item_reg.instruction),
        .pc          (pc_reg),
        .a           (op_a),
        .b           (op_b),
        .res         (ex)
    );

    // memory accesses happen in item order, one per advance
    assign pre_addr_ext = 32'(s1_item_reg.preload_address);
    assign dmem_we      = s1_adv && (preload || ex.store);
    assign dmem_waddr   = preload ? pre_addr_ext[mssc_pkg::DMEM_AW-1:0]
                                  : ex.maddr[mssc_pkg::DMEM_AW-1:0];
    assign dmem_wdata   = preload ? s1_item_reg.preload_value : op_b;
    assign dmem_re      = s1_adv && !preload && ex.load;
    assign dmem_raddr   = ex.maddr[mssc_pkg::DMEM_AW-1:0];

    mssc_ram #(
        .WIDTH (32),
        .DEPTH (mssc_pkg::DATA_DEPTH)
    ) u_dmem (
        .clk   (clk),
        .we    (dmem_we),
        .waddr (dmem_waddr),
        .wdata (dmem_wdata),
        .re    (dmem_re),
        .raddr (dmem_raddr),
        .rdata (dmem_q)
    );

    always_comb
    begin
        if (preload)
        begin
            pc_next         = pc_reg;
            s2_npc_next     = pc_reg;
            s2_rw_next      = 1'b0;
            s2_ridx_next    = '0;
            s2_rval_next    = '0;
            s2_load_next    = 1'b0;
            s2_mw_next      = 1'b1;
            s2_counted_next = 1'b0;
        end
        else
        begin
            pc_next         = ex.npc;
            s2_npc_next     = ex.npc;
            s2_rw_next      = ex.rw;
            s2_ridx_next    = ex.ridx;
            s2_rval_next    = ex.rval;
            s2_load_next    = ex.load;
            s2_mw_next      = ex.store;
            s2_counted_next = ex.counted;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s2_fresh_reg <= 1'b0;
            pc_reg       <= '0;
        end
        else
        begin
            if (req_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                s2_valid_reg <= 1'b1;
                pc_reg       <= pc_next;
            end
            else if (rsp_fire)
            begin
                s2_valid_reg <= 1'b0;
            end

            s2_fresh_reg <= s1_adv;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_item_reg <= req.payload;
        end
        if (s1_adv)
        begin
            s2_npc_reg     <= s2_npc_next;
            s2_rw_reg      <= s2_rw_next;
            s2_ridx_reg    <= s2_ridx_next;
            s2_rval_reg    <= s2_rval_next;
            s2_load_reg    <= s2_load_next;
            s2_mw_reg      <= s2_mw_next;
            s2_counted_reg <= s2_counted_next;
            s2_r0_prev_reg <= r0_nz;
        end
    end

    assign s2_value = s2_load_reg ? dmem_q : s2_rval_reg;

    // register file write in the first cycle of the result stage
    assign rf_wr.en  = s2_valid_reg && s2_fresh_reg && s2_rw_reg;
    assign rf_wr.idx = s2_ridx_reg;
    assign rf_wr.val = s2_value;

    assign rsp.valid               = s2_valid_reg;
    assign rsp.payload.next_pc     = s2_npc_reg;
    assign rsp.payload.reg_written = s2_rw_reg;
    assign rsp.payload.reg_index   = s2_ridx_reg;
    assign rsp.payload.reg_value   = s2_value;
    assign rsp.payload.mem_written = s2_mw_reg;
    assign rsp.payload.halt        = (s2_rw_reg && s2_ridx_reg == mssc_pkg::REG_ZERO)
                                     ? (s2_value != 32'd0) : s2_r0_prev_reg;
    assign rsp.payload.counted     = s2_counted_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/mssc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mssc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/mssc_regfile.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mssc_regfile (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rd_en,
    input  logic [4:0]          rs_idx,
    input  logic [4:0]          rt_idx,
    input  mssc_pkg::rf_wr_t    wr,
    output logic [31:0]         a,
    output logic [31:0]         b,
    output logic                r0_nz
);

    logic [31:0]      rs_q;
    logic [31:0]      rt_q;
    logic [31:0]      valid_reg;
    logic [4:0]       rs_idx_reg;
    logic [4:0]       rt_idx_reg;
    logic             rs_ok_reg;
    logic             rt_ok_reg;
    mssc_pkg::rf_wr_t last_reg;
    mssc_pkg::rf_wr_t prev_reg;
    logic             r0_nz_reg;

    // one copy per read port, both written together
    mssc_ram #(
        .WIDTH (32),
        .DEPTH (mssc_pkg::RF_DEPTH)
    ) u_rs_ram (
        .clk   (clk),
        .we    (wr.en),
        .waddr (wr.idx),
        .wdata (wr.val),
        .re    (rd_en),
        .raddr (rs_idx),
        .rdata (rs_q)
    );

    mssc_ram #(
        .WIDTH (32),
        .DEPTH (mssc_pkg::RF_DEPTH)
    ) u_rt_ram (
        .clk   (clk),
        .we    (wr.en),
        .waddr (wr.idx),
        .wdata (wr.val),
        .re    (rd_en),
        .raddr (rt_idx),
        .rdata (rt_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            last_reg.en  <= 1'b0;
            last_reg.idx <= '0;
            last_reg.val <= '0;
            prev_reg.en  <= 1'b0;
            prev_reg.idx <= '0;
            prev_reg.val <= '0;
            r0_nz_reg    <= 1'b0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.idx] <= 1'b1;
            last_reg          <= wr;
            prev_reg          <= last_reg;
            if (wr.idx == mssc_pkg::REG_ZERO)
            begin
                r0_nz_reg <= (wr.val != 32'd0);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rs_idx_reg <= rs_idx;
            rt_idx_reg <= rt_idx;
            rs_ok_reg  <= valid_reg[rs_idx];
            rt_ok_reg  <= valid_reg[rt_idx];
        end
    end

    // pending write first, then the two latest writes, then the array, or zero if never written
    always_comb
    begin
        if (wr.en && wr.idx == rs_idx_reg)
        begin
            a = wr.val;
        end
        else if (last_reg.en && last_reg.idx == rs_idx_reg)
        begin
            a = last_reg.val;
        end
        else if (prev_reg.en && prev_reg.idx == rs_idx_reg)
        begin
            a = prev_reg.val;
        end
        else
        begin
            a = rs_ok_reg ? rs_q : 32'd0;
        end

        if (wr.en && wr.idx == rt_idx_reg)
        begin
            b = wr.val;
        end
        else if (last_reg.en && last_reg.idx == rt_idx_reg)
        begin
            b = last_reg.val;
        end
        else if (prev_reg.en && prev_reg.idx == rt_idx_reg)
        begin
            b = prev_reg.val;
        end
        else
        begin
            b = rt_ok_reg ? rt_q : 32'd0;
        end

        if (wr.en && wr.idx == mssc_pkg::REG_ZERO)
        begin
            r0_nz = (wr.val != 32'd0);
        end
        else
        begin
            r0_nz = r0_nz_reg;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mssc_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mssc_alu (
    input  logic [31:0]     instruction,
    input  logic [31:0]     pc,
    input  logic [31:0]     a,
    input  logic [31:0]     b,
    output mssc_pkg::exec_t res
);

    logic [5:0]  op;
    logic [5:0]  fn;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  sa;
    logic [15:0] imm;
    logic [31:0] zimm;
    logic [31:0] simm;
    logic [31:0] pc4;

    assign op   = instruction[31:26];
    assign fn   = instruction[5:0];
    assign rt   = instruction[20:16];
    assign rd   = instruction[15:11];
    assign sa   = instruction[10:6];
    assign imm  = instruction[15:0];
    assign zimm = {16'd0, imm};
    assign simm = {{16{imm[15]}}, imm};
    assign pc4  = pc + 32'd4;

    always_comb
    begin
        res.npc     = pc;
        res.rw      = 1'b0;
        res.ridx    = '0;
        res.rval    = '0;
        res.load    = 1'b0;
        res.store   = 1'b0;
        res.maddr   = a + simm;
        res.counted = (instruction != 32'd0) && (instruction != 32'hffffffff);

        case (op)
            mssc_pkg::OP_RTYPE:
            begin
                res.npc = pc4;
                case (fn)
                    mssc_pkg::FN_ADD:
                    begin
                        res.rw   = 1'b1;
                        res.ridx = rd;
                        res.rval = a + b;
                    end
                    mssc_pkg::FN_SUB:
                    begin
                        res.rw   = 1'b1;
                        res.ridx = rd;
                        res.rval = a - b;
                    end
                    mssc_pkg::FN_AND:
                    begin
                        res.rw   = 1'b1;
                        res.ridx = rd;
                        res.rval = a & b;
                    end
                    mssc_pkg::FN_OR:
                    begin
                        res.rw   = 1'b1;
                        res.ridx = rd;
                        res.rval = a | b;
                    end
                    mssc_pkg::FN_SLL:
                    begin
                        res.rw   = 1'b1;
                        res.ridx = rd;
                        res.rval = b << sa;
                    end
                    mssc_pkg::FN_SRL:
                    begin
                        res.rw   = 1'b1;
                        res.ridx = rd;
                        res.rval = b >> sa;
                    end
                    mssc_pkg::FN_SLT:
                    begin
                        res.rw   = 1'b1;
                        res.ridx = rd;
                        res.rval = {31'd0, $signed(a) < $signed(b)};
                    end
                    mssc_pkg::FN_JR:
                    begin
                        res.npc = a;
                    end
                    default:
                    begin
                        res.rw = 1'b0;
                    end
                endcase
            end
            mssc_pkg::OP_LW:
            begin
                res.npc  = pc4;
                res.rw   = 1'b1;
                res.ridx = rt;
                res.load = 1'b1;
            end
            mssc_pkg::OP_SW:
            begin
                res.npc   = pc4;
                res.store = 1'b1;
            end
            mssc_pkg::OP_ANDI:
            begin
                res.npc  = pc4;
                res.rw   = 1'b1;
                res.ridx = rt;
                res.rval = a & zimm;
            end
            mssc_pkg::OP_ORI:
            begin
                res.npc  = pc4;
                res.rw   = 1'b1;
                res.ridx = rt;
                res.rval = a | zimm;
            end
            mssc_pkg::OP_ADDI:
            begin
                res.npc  = pc4;
                res.rw   = 1'b1;
                res.ridx = rt;
                res.rval = a + simm;
            end
            mssc_pkg::OP_SLTI:
            begin
                res.npc  = pc4;
                res.rw   = 1'b1;
                res.ridx = rt;
                res.rval = {31'd0, $signed(a) < $signed(simm)};
            end
            mssc_pkg::OP_LUI:
            begin
                res.npc  = pc4;
                res.rw   = 1'b1;
                res.ridx = rt;
                res.rval = {imm, 16'd0};
            end
            mssc_pkg::OP_BEQ:
            begin
                res.npc = (a == b) ? pc4 + simm : pc4;
            end
            mssc_pkg::OP_BNE:
            begin
                res.npc = (a != b) ? pc4 + simm : pc4;
            end
            mssc_pkg::OP_J:
            begin
                res.npc = {6'd0, instruction[25:0]};
            end
            mssc_pkg::OP_JAL:
            begin
                res.npc  = {6'd0, instruction[25:0]};
                res.rw   = 1'b1;
                res.ridx = mssc_pkg::REG_RA;
                res.rval = pc4;
            end
            default:
            begin
                res.npc = pc;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mssc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mssc_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_ready,
    input  logic        rsp_valid,
    input  logic        rsp_ready,
    input  logic [31:0] next_pc,
    input  logic        reg_written,
    input  logic [4:0]  reg_index,
    input  logic [31:0] reg_value,
    input  logic        halt,
    input  logic        counted
);

    logic       in_fire;
    logic       out_fire;
    logic [2:0] count_reg;
    logic       last_halt_reg;
    logic [31:0] last_pc_reg;
    logic       r0_write;

    assign in_fire  = req_valid && req_ready;
    assign out_fire = rsp_valid && rsp_ready;
    assign r0_write = reg_written && (reg_index == 5'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            last_halt_reg <= 1'b0;
            last_pc_reg   <= '0;
        end
        else
        begin
            count_reg <= count_reg + 3'(in_fire) - 3'(out_fire);
            if (out_fire)
            begin
                last_halt_reg <= halt;
                last_pc_reg   <= next_pc;
            end
        end
    end

    // protocol: a waiting result stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result withdrawn while stalled");

    // no invented results, at most two items in flight
    a_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= 3'd2) && (!rsp_valid || count_reg != 3'd0))
        else $error("items in flight out of range");

    a_halt_keep: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && !r0_write |-> halt == last_halt_reg)
        else $error("halt changed without a write to register zero");

    a_halt_set: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && r0_write |-> halt == (reg_value != 32'd0))
        else $error("halt disagrees with register zero write");

    // preloads and the all-ones word leave pc alone
    a_pc_keep: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && !counted && !reg_written |-> next_pc == last_pc_reg)
        else $error("pc moved on an item that should keep it");

endmodule

bind mips_subset_single_cycle_core_top mssc_checker u_mssc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .next_pc     (rsp.payload.next_pc),
    .reg_written (rsp.payload.reg_written),
    .reg_index   (rsp.payload.reg_index),
    .reg_value   (rsp.payload.reg_value),
    .halt        (rsp.payload.halt),
    .counted     (rsp.payload.counted)
);

`default_nettype wire
